### hdl/ddcpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcpi_pkg
// Shared types and constants of the cascaded position/velocity PI controller.
// ----------------------------------------------------------------------------
package ddcpi_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_A,
        ST_POS_B,
        ST_POS_C,
        ST_SPD_1,
        ST_SPD_2,
        ST_SPD_3,
        ST_SPD_4,
        ST_SPD_5,
        ST_SPD_6,
        ST_SPD_7,
        ST_SPD_8,
        ST_OUT
    } t_state;

    // Step strobes to the position unit
    typedef struct packed {
        logic step_a;
        logic step_b;
        logic step_c;
    } t_pos_ctl;

    // Step strobes to each speed lane
    typedef struct packed {
        logic step_1;
        logic step_2;
        logic step_3;
        logic step_4;
        logic step_5;
        logic step_6;
        logic step_7;
        logic step_8;
    } t_lane_ctl;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_LEFT  = 3'd0,
        CFG_TARGET_RIGHT = 3'd1,
        CFG_CURV_RATIO   = 3'd2,
        CFG_MAX_SPEED    = 3'd3,
        CFG_KP_LEFT      = 3'd4,
        CFG_KI_LEFT      = 3'd5,
        CFG_KP_RIGHT     = 3'd6,
        CFG_KI_RIGHT     = 3'd7
    } t_cfg_index;

    // Register reset values
    localparam logic [16:0] RATIO_RESET   = 17'd65536;
    localparam logic [19:0] MAX_SPD_RESET = 20'd25600;
    localparam logic [23:0] KP_L_RESET    = 24'd189575;
    localparam logic [23:0] KI_L_RESET    = 24'd15166;
    localparam logic [23:0] KP_R_RESET    = 24'd271790;
    localparam logic [23:0] KI_R_RESET    = 24'd13555;

    // PWM levels
    localparam logic [9:0] STOP_PWM = 10'd400;
    localparam logic [9:0] FULL_PWM = 10'd800;

    // Position loop
    localparam logic signed [32:0] TOL_POS   = 33'sd100;
    localparam logic signed [32:0] TOL_NEG   = -33'sd100;
    localparam logic [20:0]        RAMP_STEP = 21'd256;
    localparam logic [20:0]        RAMP_MAX  = 21'd1048575;
    localparam logic [16:0]        RATIO_ONE = 17'd65536;

    // Speed loop
    localparam logic [31:0]        RECIP3      = 32'h5555_5555;
    localparam logic signed [44:0] RAW_MAX     = 45'sd2147483647;
    localparam logic signed [44:0] RAW_MIN     = -45'sd2147483648;
    localparam logic signed [44:0] INT_MAX     = 45'sd2147483647;
    localparam logic signed [44:0] INT_MIN     = -45'sd2147483648;
    localparam logic signed [45:0] SUM_CLAMP   = 46'sd1099511627776;
    localparam logic signed [22:0] VOLT_TO_PWM = 23'sd3744911;
    localparam logic signed [65:0] U_STOP      = 66'sd1717986918400;
    localparam logic signed [65:0] U_FULL      = 66'sd3435973836800;

endpackage

### hdl/ddcpi_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcpi_position
// Outer position loop: tick divider, halt detect, speed ramp, wheel goals.
// ----------------------------------------------------------------------------
module ddcpi_position #(
    parameter int POSITION_DIVIDER = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ddcpi_pkg::t_pos_ctl    i_ctl,
    input  logic signed [31:0]     i_left_count,
    input  logic signed [31:0]     i_right_count,
    input  logic signed [23:0]     i_target_left,
    input  logic signed [23:0]     i_target_right,
    input  logic [16:0]            i_curvature_ratio,
    input  logic [19:0]            i_max_speed,
    output logic signed [21:0]     o_goal_left,
    output logic signed [21:0]     o_goal_right,
    output logic                   o_halted
);
    import ddcpi_pkg::*;

    localparam logic [2:0] DIV = 3'(POSITION_DIVIDER);

    logic [2:0]         r_phase;
    logic [19:0]        r_ramp;
    logic               r_halted;
    logic signed [21:0] r_goal_l, r_goal_r;
    logic signed [21:0] r_outer;
    logic               r_right_outer;
    logic               r_run;
    logic signed [39:0] r_prod;

    logic [2:0]         n_phase;
    logic               pos_tick;
    logic signed [32:0] err_l, err_r, err_o;
    logic               in_tol;
    logic [20:0]        ramp_sum;
    logic [19:0]        n_ramp;
    logic signed [43:0] scaled, lim_x;
    logic signed [21:0] outer;
    logic               right_outer;
    logic [16:0]        ratio;
    logic signed [39:0] rnd;

    // Position tick, tolerance and ramp
    always_comb begin
        n_phase     = r_phase + 3'd1;
        pos_tick    = (n_phase >= DIV);
        err_l       = 33'(i_target_left) - 33'(i_left_count);
        err_r       = 33'(i_target_right) - 33'(i_right_count);
        in_tol      = (err_l > TOL_NEG) && (err_l < TOL_POS) &&
                      (err_r > TOL_NEG) && (err_r < TOL_POS);
        ramp_sum    = {1'b0, r_ramp} + RAMP_STEP;
        if (r_ramp < i_max_speed) begin
            n_ramp = (ramp_sum > RAMP_MAX) ? RAMP_MAX[19:0] : ramp_sum[19:0];
        end else begin
            n_ramp = r_ramp;
        end
        right_outer = (i_target_left < i_target_right);
        err_o       = right_outer ? err_r : err_l;
        // error times 1280 as shift-add
        scaled      = (44'(err_o) <<< 10) + (44'(err_o) <<< 8);
        lim_x       = 44'({1'b0, n_ramp});
        if (scaled > lim_x) begin
            outer = 22'(lim_x);
        end else if (scaled < -lim_x) begin
            outer = 22'(-lim_x);
        end else begin
            outer = 22'(scaled);
        end
    end

    // Inner-wheel ratio, capped at one
    assign ratio = (i_curvature_ratio > RATIO_ONE) ? RATIO_ONE : i_curvature_ratio;

    // Round to nearest, ties away from zero
    assign rnd = r_prod + 40'sd32768 - 40'(r_prod[39]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_ramp   <= '0;
            r_halted <= 1'b0;
            r_goal_l <= '0;
            r_goal_r <= '0;
            r_run    <= 1'b0;
        end else begin
            if (i_ctl.step_a) begin
                r_run <= 1'b0;
                if (!r_halted) begin
                    r_phase <= pos_tick ? 3'd0 : n_phase;
                    if (pos_tick) begin
                        if (in_tol) begin
                            r_halted <= 1'b1;
                        end else begin
                            r_ramp <= n_ramp;
                            r_run  <= 1'b1;
                        end
                    end
                end
            end
            if (i_ctl.step_c && r_run) begin
                if (r_right_outer) begin
                    r_goal_r <= r_outer;
                    r_goal_l <= rnd[37:16];
                end else begin
                    r_goal_l <= r_outer;
                    r_goal_r <= rnd[37:16];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.step_a) begin
            r_outer       <= outer;
            r_right_outer <= right_outer;
        end
        if (i_ctl.step_b) begin
            r_prod <= 40'(r_outer) * 40'($signed({1'b0, ratio}));
        end
    end

    assign o_goal_left  = r_goal_l;
    assign o_goal_right = r_goal_r;
    assign o_halted     = r_halted;

endmodule

### hdl/ddcpi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcpi_lane
// One wheel's speed loop: speed estimate, 3-tap mean, PI with anti-windup.
// ----------------------------------------------------------------------------
module ddcpi_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ddcpi_pkg::t_lane_ctl  i_ctl,
    input  logic signed [31:0]    i_count,
    input  logic signed [21:0]    i_goal,
    input  logic [23:0]           i_kp,
    input  logic [23:0]           i_ki,
    output logic [9:0]            o_pwm
);
    import ddcpi_pkg::*;

    // Loop state
    logic signed [31:0] r_prev, r_h0, r_h1, r_integ;
    // Pipeline registers
    logic [33:0]        r_x, r_q0;
    logic               r_neg;
    logic signed [34:0] r_err;
    logic signed [59:0] r_pi, r_pp;
    logic signed [43:0] r_ri, r_rp;
    logic signed [31:0] r_cand;
    logic signed [41:0] r_sum;
    logic signed [65:0] r_u;
    logic [9:0]         r_pwm;

    logic signed [31:0] diff, raw;
    logic signed [44:0] scaled;
    logic signed [33:0] s;
    logic [33:0]        x;
    logic [65:0]        q_prod;
    logic [35:0]        rem;
    logic [33:0]        q;
    logic signed [34:0] filt;
    logic signed [59:0] rnd_i, rnd_p;
    logic signed [44:0] cand_w;
    logic signed [31:0] cand;
    logic signed [45:0] sum_w;
    logic signed [41:0] sum_c;

    // Step 1: raw speed, window sum, magnitude plus one
    always_comb begin
        diff   = i_count - r_prev;
        scaled = (45'(diff) <<< 12) + (45'(diff) <<< 11) + (45'(diff) <<< 8);
        if (scaled > RAW_MAX) begin
            raw = RAW_MAX[31:0];
        end else if (scaled < RAW_MIN) begin
            raw = RAW_MIN[31:0];
        end else begin
            raw = scaled[31:0];
        end
        s = 34'(r_h0) + 34'(r_h1) + 34'(raw);
        x = s[33] ? (~s + 34'd2) : (s + 34'd1);
    end

    // Steps 2 and 3: divide by three through the reciprocal plus correction
    assign q_prod = 66'(r_x) * 66'(RECIP3);
    always_comb begin
        rem = 36'(r_x) - (36'(r_q0) + (36'(r_q0) << 1));
        if (rem >= 36'd6) begin
            q = r_q0 + 34'd2;
        end else if (rem >= 36'd3) begin
            q = r_q0 + 34'd1;
        end else begin
            q = r_q0;
        end
        filt = r_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    // Step 5: round Q32 products to Q16
    assign rnd_i = r_pi + 60'sd32768 - 60'(r_pi[59]);
    assign rnd_p = r_pp + 60'sd32768 - 60'(r_pp[59]);

    // Step 6: integrator candidate and clamped PI sum
    always_comb begin
        cand_w = 45'(r_integ) + 45'(r_ri);
        if (cand_w > INT_MAX) begin
            cand = INT_MAX[31:0];
        end else if (cand_w < INT_MIN) begin
            cand = INT_MIN[31:0];
        end else begin
            cand = cand_w[31:0];
        end
        sum_w = 46'(r_rp) + 46'(cand);
        if (sum_w > SUM_CLAMP) begin
            sum_c = 42'(SUM_CLAMP);
        end else if (sum_w < -SUM_CLAMP) begin
            sum_c = 42'(-SUM_CLAMP);
        end else begin
            sum_c = 42'(sum_w);
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_h0    <= '0;
            r_h1    <= '0;
            r_integ <= '0;
        end else begin
            if (i_ctl.step_1) begin
                r_prev <= i_count;
                r_h0   <= r_h1;
                r_h1   <= raw;
            end
            // anti-windup: keep old integrator when the output saturates
            if (i_ctl.step_8 && !(r_u > U_FULL) && !r_u[65]) begin
                r_integ <= r_cand;
            end
        end
    end

    // Datapath pipeline
    always_ff @(posedge i_clk) begin
        if (i_ctl.step_1) begin
            r_x   <= x;
            r_neg <= s[33];
        end
        if (i_ctl.step_2) begin
            r_q0 <= q_prod[65:32];
        end
        if (i_ctl.step_3) begin
            r_err <= 35'(i_goal) - filt;
        end
        if (i_ctl.step_4) begin
            r_pi <= 60'($signed({1'b0, i_ki})) * 60'(r_err);
            r_pp <= 60'($signed({1'b0, i_kp})) * 60'(r_err);
        end
        if (i_ctl.step_5) begin
            r_ri <= rnd_i[59:16];
            r_rp <= rnd_p[59:16];
        end
        if (i_ctl.step_6) begin
            r_cand <= cand;
            r_sum  <= sum_c;
        end
        if (i_ctl.step_7) begin
            r_u <= U_STOP - 66'(r_sum) * 66'(VOLT_TO_PWM);
        end
        if (i_ctl.step_8) begin
            if (r_u > U_FULL) begin
                r_pwm <= FULL_PWM;
            end else if (r_u[65]) begin
                r_pwm <= '0;
            end else begin
                r_pwm <= r_u[41:32];
            end
        end
    end

    assign o_pwm = r_pwm;

endmodule

### hdl/differential_drive_cascade_pi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_cascade_pi
// Two-wheel cascaded position/velocity PI controller, one result per tick.
// ----------------------------------------------------------------------------
// A tick runs from input transfer to result in the output register through
// the accept state, 3 position-loop steps, 8 speed-loop steps and the merge
// state; once the controller has halted the speed-loop steps are skipped. The
// sequencer steps the position unit and the two wheel lanes, which run side by
// side through their shared steps. One tick is worked at a time; the next tick
// is taken while the previous result waits in the output register.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
module differential_drive_cascade_pi #(
    parameter int POSITION_DIVIDER = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input ticks
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] left_count, [63:32] right_count
    // Results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [9:0] left_pwm, [19:10] right_pwm, rest 0
    output logic [0:0]  o_m_axis_tuser,   // [0] done_res
    // Configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import ddcpi_pkg::*;

    t_state r_state, n_state;

    logic signed [23:0] r_target_l, r_target_r;
    logic [16:0]        r_ratio;
    logic [19:0]        r_max_speed;
    logic [23:0]        r_kp_l, r_ki_l, r_kp_r, r_ki_r;

    logic signed [31:0] r_left_count, r_right_count;
    logic               r_o_valid;
    logic [9:0]         r_o_left, r_o_right;
    logic               r_o_done;

    t_pos_ctl           pos_ctl;
    t_lane_ctl          lane_ctl;
    logic               s_ready, out_load;
    logic signed [21:0] goal_l, goal_r;
    logic               halted;
    logic [9:0]         pwm_l, pwm_r;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_l  <= '0;
            r_target_r  <= '0;
            r_ratio     <= RATIO_RESET;
            r_max_speed <= MAX_SPD_RESET;
            r_kp_l      <= KP_L_RESET;
            r_ki_l      <= KI_L_RESET;
            r_kp_r      <= KP_R_RESET;
            r_ki_r      <= KI_R_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_LEFT:  r_target_l  <= i_cfg_data;
                CFG_TARGET_RIGHT: r_target_r  <= i_cfg_data;
                CFG_CURV_RATIO:   r_ratio     <= i_cfg_data[16:0];
                CFG_MAX_SPEED:    r_max_speed <= i_cfg_data[19:0];
                CFG_KP_LEFT:      r_kp_l      <= i_cfg_data;
                CFG_KI_LEFT:      r_ki_l      <= i_cfg_data;
                CFG_KP_RIGHT:     r_kp_r      <= i_cfg_data;
                CFG_KI_RIGHT:     r_ki_r      <= i_cfg_data;
                default:          ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_POS_A;
            ST_POS_A: n_state = ST_POS_B;
            ST_POS_B: n_state = ST_POS_C;
            ST_POS_C: n_state = halted ? ST_OUT : ST_SPD_1;
            ST_SPD_1: n_state = ST_SPD_2;
            ST_SPD_2: n_state = ST_SPD_3;
            ST_SPD_3: n_state = ST_SPD_4;
            ST_SPD_4: n_state = ST_SPD_5;
            ST_SPD_5: n_state = ST_SPD_6;
            ST_SPD_6: n_state = ST_SPD_7;
            ST_SPD_7: n_state = ST_SPD_8;
            ST_SPD_8: n_state = ST_OUT;
            ST_OUT:   if (!r_o_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        pos_ctl  = '0;
        lane_ctl = '0;
        s_ready  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_ready = 1'b1;
            ST_POS_A: pos_ctl.step_a = 1'b1;
            ST_POS_B: pos_ctl.step_b = 1'b1;
            ST_POS_C: pos_ctl.step_c = 1'b1;
            ST_SPD_1: lane_ctl.step_1 = 1'b1;
            ST_SPD_2: lane_ctl.step_2 = 1'b1;
            ST_SPD_3: lane_ctl.step_3 = 1'b1;
            ST_SPD_4: lane_ctl.step_4 = 1'b1;
            ST_SPD_5: lane_ctl.step_5 = 1'b1;
            ST_SPD_6: lane_ctl.step_6 = 1'b1;
            ST_SPD_7: lane_ctl.step_7 = 1'b1;
            ST_SPD_8: lane_ctl.step_8 = 1'b1;
            ST_OUT:   out_load = !r_o_valid || i_m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_left_count  <= i_s_axis_tdata[31:0];
            r_right_count <= i_s_axis_tdata[63:32];
        end
    end
    assign o_s_axis_tready = s_ready;

    // Position loop
    ddcpi_position #(
        .POSITION_DIVIDER (POSITION_DIVIDER)
    ) u_position (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (pos_ctl),
        .i_left_count      (r_left_count),
        .i_right_count     (r_right_count),
        .i_target_left     (r_target_l),
        .i_target_right    (r_target_r),
        .i_curvature_ratio (r_ratio),
        .i_max_speed       (r_max_speed),
        .o_goal_left       (goal_l),
        .o_goal_right      (goal_r),
        .o_halted          (halted)
    );

    // Speed lanes
    ddcpi_lane u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_count (r_left_count),
        .i_goal  (goal_l),
        .i_kp    (r_kp_l),
        .i_ki    (r_ki_l),
        .o_pwm   (pwm_l)
    );

    ddcpi_lane u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_count (r_right_count),
        .i_goal  (goal_r),
        .i_kp    (r_kp_r),
        .i_ki    (r_ki_r),
        .o_pwm   (pwm_r)
    );

    // Merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_left  <= halted ? STOP_PWM : pwm_l;
            r_o_right <= halted ? STOP_PWM : pwm_r;
            r_o_done  <= halted;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_right, r_o_left};
    assign o_m_axis_tuser  = r_o_done;

endmodule

### hdl/ddcpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcpi_checker
// Port-level checks of the controller's result stream.
// ----------------------------------------------------------------------------
module ddcpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);
    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A halted result holds both motors stopped
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tdata[9:0] == 10'd400 && o_m_axis_tdata[19:10] == 10'd400))
        else $error("done result without stopped motors");

    // PWM values stay in range, padding is zero
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (o_m_axis_tdata[9:0] <= 10'd800 && o_m_axis_tdata[19:10] <= 10'd800 &&
         o_m_axis_tdata[23:20] == 4'd0))
        else $error("pwm out of range");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind differential_drive_cascade_pi ddcpi_checker u_ddcpi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the two-wheel cascaded position/velocity PI controller.
// Encoder ticks are streamed in with random gaps and output back-pressure.
// A behavioral controller model inside the bench predicts the two PWM values
// and the done flag of every tick, and each result is checked in order.
// Registers are rewritten between phases while the block is idle, and the
// last test drives both wheels onto target so that the controller halts.
// ----------------------------------------------------------------------------
module tb;
    import ddcpi_pkg::*;

    typedef struct {
        logic [9:0] left_pwm;
        logic [9:0] right_pwm;
        logic       done;
    } t_pwm_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // [31:0] left_count, [63:32] right_count
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // [9:0] left_pwm, [19:10] right_pwm
    logic [0:0]  o_m_axis_tuser;   // [0] done_res
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    differential_drive_cascade_pi dut (.*);

    // Controller model state
    longint      tgt_l, tgt_r, ratio_q16, max_spd;
    longint      kp [2];
    longint      ki [2];
    int unsigned phase_cnt;
    longint      ramp;
    longint      goal [2];
    logic [31:0] prev_cnt [2];
    longint      hist_old [2];
    longint      hist_new [2];
    longint      integ [2];
    bit          halted;

    t_pwm_result pwm_expect_q [$];
    int          fail_cnt;
    bit          idle_on;       // random gaps enabled
    bit          hold_req;      // ask receiver for a long hold-off
    longint      walk_l, walk_r;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint round_q(longint v, int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (v >= 0) return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // One wheel's speed PI; updates that wheel's history and integrator
    function automatic logic [9:0] wheel_pwm(int w, logic [31:0] cnt);
        logic [31:0] d32;
        longint raw, s, filt, e, cand, sum, u;
        d32  = cnt - prev_cnt[w];
        raw  = sat_s32(longint'($signed(d32)) * 6400);
        s    = hist_old[w] + hist_new[w] + raw;
        filt = (s >= 0) ? (s + 1) / 3 : -((-s + 1) / 3);
        prev_cnt[w] = cnt;
        hist_old[w] = hist_new[w];
        hist_new[w] = raw;
        e    = goal[w] - filt;
        cand = sat_s32(integ[w] + round_q(ki[w] * e, 16));
        sum  = clamp_mag(round_q(kp[w] * e, 16) + cand, 64'sd1099511627776);
        u    = (longint'(400) <<< 32) - sum * 3744911;
        if (u > (longint'(800) <<< 32)) return FULL_PWM;
        if (u < 0) return 10'd0;
        integ[w] = cand;
        return 10'(u >>> 32);
    endfunction

    function automatic t_pwm_result predict_tick(logic [31:0] lc, logic [31:0] rc);
        t_pwm_result res;
        longint el, er, rat, outer;
        if (!halted) begin
            phase_cnt = (phase_cnt + 1) & 7;
            if (phase_cnt >= 5) begin
                el  = tgt_l - longint'($signed(lc));
                er  = tgt_r - longint'($signed(rc));
                rat = (ratio_q16 > 65536) ? 65536 : ratio_q16;
                phase_cnt = 0;
                if (el > -100 && el < 100 && er > -100 && er < 100) begin
                    halted = 1'b1;
                end else begin
                    if (ramp < max_spd) begin
                        ramp += 256;
                        if (ramp > 1048575) ramp = 1048575;
                    end
                    if (tgt_l < tgt_r) begin
                        outer   = clamp_mag(er * 1280, ramp);
                        goal[1] = outer;
                        goal[0] = round_q(outer * rat, 16);
                    end else begin
                        outer   = clamp_mag(el * 1280, ramp);
                        goal[0] = outer;
                        goal[1] = round_q(outer * rat, 16);
                    end
                end
            end
        end
        if (halted) begin
            res.left_pwm = STOP_PWM;
            res.right_pwm = STOP_PWM;
            res.done = 1'b1;
            return res;
        end
        res.left_pwm  = wheel_pwm(0, lc);
        res.right_pwm = wheel_pwm(1, rc);
        res.done      = 1'b0;
        return res;
    endfunction

    function automatic void apply_reg(t_cfg_index idx, logic [23:0] v);
        case (idx)
            CFG_TARGET_LEFT:  tgt_l = longint'($signed(v));
            CFG_TARGET_RIGHT: tgt_r = longint'($signed(v));
            CFG_CURV_RATIO:   ratio_q16 = v[16:0];
            CFG_MAX_SPEED:    max_spd = v[19:0];
            CFG_KP_LEFT:      kp[0] = v;
            CFG_KI_LEFT:      ki[0] = v;
            CFG_KP_RIGHT:     kp[1] = v;
            CFG_KI_RIGHT:     ki[1] = v;
            default: ;
        endcase
    endfunction

    // Model tracks every accepted tick and register write
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            pwm_expect_q.push_back(predict_tick(i_s_axis_tdata[31:0],
                                                i_s_axis_tdata[63:32]));
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            apply_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_pwm_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pwm_expect_q.size() == 0) begin
                $display("%0t: unexpected result pwm %0d/%0d done %0d", $time,
                         o_m_axis_tdata[9:0], o_m_axis_tdata[19:10], o_m_axis_tuser[0]);
                fail_cnt++;
            end else begin
                exp_r = pwm_expect_q.pop_front();
                if (o_m_axis_tdata[9:0] !== exp_r.left_pwm) begin
                    $display("%0t: left_pwm expected %0d actual %0d", $time,
                             exp_r.left_pwm, o_m_axis_tdata[9:0]);
                    fail_cnt++;
                end
                if (o_m_axis_tdata[19:10] !== exp_r.right_pwm) begin
                    $display("%0t: right_pwm expected %0d actual %0d", $time,
                             exp_r.right_pwm, o_m_axis_tdata[19:10]);
                    fail_cnt++;
                end
                if (o_m_axis_tuser[0] !== exp_r.done) begin
                    $display("%0t: done expected %0d actual %0d", $time,
                             exp_r.done, o_m_axis_tuser[0]);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (pick_gap() != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(logic [31:0] lc, logic [31:0] rc);
        int gap;
        i_s_axis_tdata  <= {rc, lc};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Same as send_tick but keeps the left wheel out of the stop window
    task automatic send_moving(logic [31:0] lc, logic [31:0] rc);
        longint dl;
        dl = tgt_l - longint'($signed(lc));
        if (dl > -100 && dl < 100) lc = lc + 32'd1000;
        send_tick(lc, rc);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [23:0] v);
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Let all outstanding ticks drain before touching registers
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic load_regs(logic [23:0] tl, logic [23:0] tr, logic [23:0] rat,
                             logic [23:0] mx, logic [23:0] kpl, logic [23:0] kil,
                             logic [23:0] kpr, logic [23:0] kir);
        wait_idle();
        write_reg(CFG_TARGET_LEFT, tl);
        write_reg(CFG_TARGET_RIGHT, tr);
        write_reg(CFG_CURV_RATIO, rat);
        write_reg(CFG_MAX_SPEED, mx);
        write_reg(CFG_KP_LEFT, kpl);
        write_reg(CFG_KI_LEFT, kil);
        write_reg(CFG_KP_RIGHT, kpr);
        write_reg(CFG_KI_RIGHT, kir);
    endtask

    // Mostly smooth encoder motion, some wide jumps and full-range noise
    task automatic random_run(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                walk_l += $urandom_range(0, 80) - 40;
                walk_r += $urandom_range(0, 80) - 40;
            end else if (r < 90) begin
                walk_l += $urandom_range(0, 200000) - 100000;
                walk_r += $urandom_range(0, 200000) - 100000;
            end else begin
                walk_l = $urandom;
                walk_r = $urandom;
            end
            send_moving(walk_l[31:0], walk_r[31:0]);
        end
    endtask

    // Defaults apart from targets, then field extremes and encoder wrap
    task automatic test_directed();
        load_regs(24'h7FFFFF, 24'h800000, 24'(RATIO_RESET), 24'(MAX_SPD_RESET),
                  24'(KP_L_RESET), 24'(KI_L_RESET), 24'(KP_R_RESET), 24'(KI_R_RESET));
        send_moving(32'd0, 32'd0);
        send_moving(32'h7FFFFFFF, 32'h80000000);
        send_moving(32'h80000000, 32'h7FFFFFFF);
        send_moving(32'hFFFFFFFF, 32'h00000001);
        send_moving(32'h00000001, 32'hFFFFFFFF);
        for (int i = 0; i < 10; i++) send_moving(32'(i * 50), 32'(-i * 50));
        send_moving(32'h00400000, 32'hFFC00000);
        send_moving(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_moving(32'h55555555, 32'hAAAAAAAA);
        send_moving(32'hAAAAAAAA, 32'h55555555);
        send_moving(32'd0, 32'd0);
    endtask

    // Several register settings, extremes included, each with random ticks
    task automatic test_settings();
        idle_on = 1'b0;
        load_regs(24'd5000, 24'd90000, 24'd32768, 24'd25600,
                  24'(KP_L_RESET), 24'(KI_L_RESET), 24'(KP_R_RESET), 24'(KI_R_RESET));
        walk_l = 0; walk_r = 0;
        random_run(60);
        idle_on = 1'b1;
        load_regs(24'hFFFF00, 24'd100, 24'd0, 24'd0,
                  24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
        random_run(60);
        load_regs(24'd300, 24'd300, 24'd131071, 24'hFFFFF,
                  24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0);
        random_run(60);
        load_regs(24'h800000, 24'h7FFFFF, 24'd65536, 24'd1048320,
                  24'd4000000, 24'd500000, 24'd4000000, 24'd500000);
        random_run(60);
        load_regs(24'd200000, 24'hFF0000, 24'd49152, 24'd512,
                  24'd189575, 24'd15166, 24'd271790, 24'd13555);
        random_run(60);
        for (int p = 0; p < 3; p++) begin
            load_regs(24'($urandom), 24'($urandom), 24'($urandom_range(0, 131071)),
                      24'($urandom_range(0, 1048575)), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom));
            random_run(50);
        end
    endtask

    // Receiver holds off long while ticks keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        random_run(40);
    endtask

    // Both wheels reach target: the block stops and stays stopped
    task automatic test_halt();
        load_regs(24'd1000, 24'hFFFC18, 24'd65536, 24'd25600,
                  24'(KP_L_RESET), 24'(KI_L_RESET), 24'(KP_R_RESET), 24'(KI_R_RESET));
        for (int i = 0; i < 6; i++) send_tick(32'd1099, -32'sd901);
        for (int i = 0; i < 6; i++) send_tick(32'd901, -32'sd1099);
        for (int i = 0; i < 8; i++) send_tick($urandom, $urandom);
    endtask

    // Test sequence
    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        fail_cnt = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        walk_l = 0; walk_r = 0;
        tgt_l = 0; tgt_r = 0;
        ratio_q16 = RATIO_RESET; max_spd = MAX_SPD_RESET;
        kp[0] = KP_L_RESET; ki[0] = KI_L_RESET;
        kp[1] = KP_R_RESET; ki[1] = KI_R_RESET;
        phase_cnt = 0; ramp = 0; halted = 1'b0;
        for (int w = 0; w < 2; w++) begin
            goal[w] = 0; prev_cnt[w] = '0; hist_old[w] = 0;
            hist_new[w] = 0; integ[w] = 0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_settings();
        test_backpressure();
        test_halt();

        i_s_axis_tvalid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0 && pwm_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
